// ===== design/cau_pkg.sv =====
// Shared types, sizes and helpers for the complex arithmetic unit.
// Used by every module of the block; depends on nothing.
package cau_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	localparam int AW    = DATA_WIDTH + 1;
	localparam int PW    = 2 * DATA_WIDTH;
	localparam int SQW   = 2 * AW;
	localparam int SW    = PW + 1;
	localparam int QW    = DATA_WIDTH + 2;
	localparam int NSTEP = QW;
	localparam int SQRW  = 2 * QW - 1;
	localparam int NW    = SW - 1 + FRAC_BITS;
	localparam int DVW   = PW + QW - 1;
	localparam int DIRW  = SW - FRAC_BITS;

	localparam logic signed [DIRW-1:0] DMAX = DIRW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [DIRW-1:0] DMIN = -DMAX - DIRW'(1);

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_DIST = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_SAT  = 2'd2,
		ST_INV  = 2'd3
	} status_t;

	typedef struct packed {
		op_t                    op;
		logic signed [DIRW-1:0] dir_r;
		logic signed [DIRW-1:0] dir_i;
		logic                   zero;
		logic                   neg_r;
		logic                   neg_i;
		logic [NW-1:0]          rem_r;
		logic [NW-1:0]          rem_i;
		logic [QW-1:0]          q_r;
		logic [QW-1:0]          q_i;
		logic [DVW-1:0]         dvs;
		logic [SQRW-1:0]        sq_n;
		logic [SQRW-1:0]        sq_res;
		logic [SQRW-1:0]        sq_bit;
	} step_t;

	function automatic logic [DATA_WIDTH-1:0] sat_val(input logic signed [DIRW-1:0] x);
		if (x > DMAX) return DMAX[DATA_WIDTH-1:0];
		if (x < DMIN) return DMIN[DATA_WIDTH-1:0];
		return x[DATA_WIDTH-1:0];
	endfunction

	function automatic logic is_sat(input logic signed [DIRW-1:0] x);
		return (x > DMAX) || (x < DMIN);
	endfunction

endpackage

// ===== design/cau_front.sv =====
// Front end: operand register, six multipliers, sums, divider and root setup.
// Three register stages; depends on cau_pkg.
module cau_front import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  op_t                          in_op,
	input  logic signed [DATA_WIDTH-1:0] in_ar,
	input  logic signed [DATA_WIDTH-1:0] in_ai,
	input  logic signed [DATA_WIDTH-1:0] in_br,
	input  logic signed [DATA_WIDTH-1:0] in_bi,
	output logic                         out_valid,
	input  logic                         out_ready,
	output step_t                        out_step
);

	logic vld_s1, vld_s2, vld_s3;
	logic ld1, ld2, ld3;

	op_t                          op_s1, op_s2, op_s3;
	logic signed [DATA_WIDTH-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [AW-1:0]         xa_s1, xb_s1, asr_s1, asi_s1;
	logic signed [AW-1:0]         asr_s2, asi_s2, asr_s3, asi_s3;
	logic signed [PW-1:0]         p0_s2, p1_s2, p2_s2, p3_s2;
	logic [SQW-1:0]               p4_s2, p5_s2;
	logic signed [SW-1:0]         sr_s3, si_s3;
	logic [SQRW-1:0]              msq_s3;

	logic signed [AW-1:0] dr, di, xa, xb, asr, asi;
	logic [SW-1:0]        abs_r, abs_i;

	assign ld3      = !vld_s3 || out_ready;
	assign ld2      = !vld_s2 || ld3;
	assign ld1      = !vld_s1 || ld2;
	assign in_ready = ld1;

	always_comb begin
		dr  = AW'(in_ar) - AW'(in_br);
		di  = AW'(in_ai) - AW'(in_bi);
		xa  = (in_op == OP_DIST) ? dr : AW'(in_br);
		xb  = (in_op == OP_DIST) ? di : AW'(in_bi);
		asr = (in_op == OP_SUB) ? dr : AW'(in_ar) + AW'(in_br);
		asi = (in_op == OP_SUB) ? di : AW'(in_ai) + AW'(in_bi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= in_valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			op_s1  <= in_op;
			ar_s1  <= in_ar;
			ai_s1  <= in_ai;
			br_s1  <= in_br;
			bi_s1  <= in_bi;
			xa_s1  <= xa;
			xb_s1  <= xb;
			asr_s1 <= asr;
			asi_s1 <= asi;
		end
		if (ld2 && vld_s1) begin
			op_s2  <= op_s1;
			p0_s2  <= PW'(ar_s1) * PW'(br_s1);
			p1_s2  <= PW'(ai_s1) * PW'(bi_s1);
			p2_s2  <= PW'(ar_s1) * PW'(bi_s1);
			p3_s2  <= PW'(ai_s1) * PW'(br_s1);
			p4_s2  <= SQW'(xa_s1) * SQW'(xa_s1);
			p5_s2  <= SQW'(xb_s1) * SQW'(xb_s1);
			asr_s2 <= asr_s1;
			asi_s2 <= asi_s1;
		end
		if (ld3 && vld_s2) begin
			op_s3  <= op_s2;
			sr_s3  <= (op_s2 == OP_MUL) ? SW'(p0_s2) - SW'(p1_s2) : SW'(p0_s2) + SW'(p1_s2);
			si_s3  <= (op_s2 == OP_MUL) ? SW'(p2_s2) + SW'(p3_s2) : SW'(p3_s2) - SW'(p2_s2);
			msq_s3 <= SQRW'(p4_s2) + SQRW'(p5_s2);
			asr_s3 <= asr_s2;
			asi_s3 <= asi_s2;
		end
	end

	always_comb begin
		abs_r = sr_s3[SW-1] ? -sr_s3 : sr_s3;
		abs_i = si_s3[SW-1] ? -si_s3 : si_s3;
		out_step.op     = op_s3;
		out_step.dir_r  = (op_s3 == OP_MUL) ? DIRW'(sr_s3 >>> FRAC_BITS) : DIRW'(asr_s3);
		out_step.dir_i  = (op_s3 == OP_MUL) ? DIRW'(si_s3 >>> FRAC_BITS) : DIRW'(asi_s3);
		out_step.zero   = (msq_s3 == '0);
		out_step.neg_r  = sr_s3[SW-1];
		out_step.neg_i  = si_s3[SW-1];
		out_step.rem_r  = NW'(abs_r[SW-2:0]) << FRAC_BITS;
		out_step.rem_i  = NW'(abs_i[SW-2:0]) << FRAC_BITS;
		out_step.q_r    = '0;
		out_step.q_i    = '0;
		out_step.dvs    = DVW'(msq_s3[PW-1:0]) << (QW - 1);
		out_step.sq_n   = msq_s3;
		out_step.sq_res = '0;
		out_step.sq_bit = SQRW'(1) << (2 * (QW - 1));
	end

	assign out_valid = vld_s3;

endmodule

// ===== design/cau_step.sv =====
// One iteration stage: one quotient bit for both divide lanes and one root bit.
// Depends on cau_pkg.
module cau_step import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  step_t in_step,
	output logic  out_valid,
	input  logic  out_ready,
	output step_t out_step
);

	logic  vld_s1;
	step_t step_s1;
	step_t nxt;
	logic  ge_r, ge_i, ge_s;
	logic [SQRW-1:0] trial;

	assign in_ready = !vld_s1 || out_ready;

	always_comb begin
		nxt   = in_step;
		ge_r  = DVW'(in_step.rem_r) >= in_step.dvs;
		ge_i  = DVW'(in_step.rem_i) >= in_step.dvs;
		trial = in_step.sq_res + in_step.sq_bit;
		ge_s  = in_step.sq_n >= trial;
		if (ge_r) nxt.rem_r = in_step.rem_r - in_step.dvs[NW-1:0];
		if (ge_i) nxt.rem_i = in_step.rem_i - in_step.dvs[NW-1:0];
		nxt.q_r = {in_step.q_r[QW-2:0], ge_r};
		nxt.q_i = {in_step.q_i[QW-2:0], ge_i};
		nxt.dvs = in_step.dvs >> 1;
		if (ge_s) begin
			nxt.sq_n   = in_step.sq_n - trial;
			nxt.sq_res = (in_step.sq_res >> 1) + in_step.sq_bit;
		end else begin
			nxt.sq_res = in_step.sq_res >> 1;
		end
		nxt.sq_bit = in_step.sq_bit >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) step_s1 <= nxt;
	end

	assign out_valid = vld_s1;
	assign out_step  = step_s1;

endmodule

// ===== design/cau_back.sv =====
// Result stage: signs the quotients, clamps, sets status, holds the output item.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  step_t                 in_step,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] res_r,
	output logic [DATA_WIDTH-1:0] res_i,
	output status_t               status
);

	logic                  vld_s1;
	logic [DATA_WIDTH-1:0] rr_s1, ri_s1;
	status_t               st_s1;

	logic signed [DIRW-1:0] vr, vi;
	logic [DATA_WIDTH-1:0]  nr, ni;
	status_t                st;

	assign in_ready = !vld_s1 || out_ready;

	always_comb begin
		vr = '0;
		vi = '0;
		st = ST_OK;
		case (in_step.op)
			OP_ADD, OP_SUB, OP_MUL: begin
				vr = in_step.dir_r;
				vi = in_step.dir_i;
			end
			OP_DIV: begin
				if (in_step.zero) begin
					st = ST_DIVZ;
				end else begin
					vr = in_step.neg_r ? -DIRW'(in_step.q_r) : DIRW'(in_step.q_r);
					vi = in_step.neg_i ? -DIRW'(in_step.q_i) : DIRW'(in_step.q_i);
				end
			end
			OP_DIST: begin
				vr = DIRW'(in_step.sq_res[QW-1:0]);
			end
			default: begin
				st = ST_INV;
			end
		endcase
		nr = '0;
		ni = '0;
		if (st == ST_OK) begin
			nr = sat_val(vr);
			ni = sat_val(vi);
			if (is_sat(vr) || is_sat(vi)) st = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rr_s1 <= nr;
			ri_s1 <= ni;
			st_s1 <= st;
		end
	end

	assign out_valid = vld_s1;
	assign res_r     = rr_s1;
	assign res_i     = ri_s1;
	assign status    = st_s1;

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && st_s1 == ST_INV |-> rr_s1 == '0 && ri_s1 == '0)
		else $error("invalid operation gave nonzero result");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && st_s1 == ST_DIVZ |-> rr_s1 == '0 && ri_s1 == '0)
		else $error("zero divisor gave nonzero result");

	a_dist_imag: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && in_valid && in_step.op == OP_DIST |=> ri_s1 == '0)
		else $error("distance gave nonzero imaginary part");

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide, distance in Q8.8.
// Pipeline: 3 front stages, 18 divide/root bit stages, 1 result stage.
// Throughput one item per cycle while m_tready stays high; the bit stages set the depth.
// Each stage holds on a stall and takes a new item when it is empty or its item moves on.
// arst_n clears all valid bits; the pipeline is empty after reset.
module complex_arithmetic_unit import cau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // a_real, a_imag, b_real, b_imag
	input  logic [2:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_real, result_imag
	output logic [1:0]  m_tuser    // status
);

	step_t chain_d [NSTEP+1];
	logic  chain_v [NSTEP+1];
	logic  chain_r [NSTEP+1];
	status_t st;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser)),
		.in_ar     (s_tdata[DATA_WIDTH-1:0]),
		.in_ai     (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.in_br     (s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
		.in_bi     (s_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH]),
		.out_valid (chain_v[0]),
		.out_ready (chain_r[0]),
		.out_step  (chain_d[0])
	);

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		cau_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[k]),
			.in_ready  (chain_r[k]),
			.in_step   (chain_d[k]),
			.out_valid (chain_v[k+1]),
			.out_ready (chain_r[k+1]),
			.out_step  (chain_d[k+1])
		);
	end

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_v[NSTEP]),
		.in_ready  (chain_r[NSTEP]),
		.in_step   (chain_d[NSTEP]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_r     (m_tdata[DATA_WIDTH-1:0]),
		.res_i     (m_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.status    (st)
	);

	assign m_tuser = st;

endmodule
